[rtl/mrc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// read-input-registers reply checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int unsigned MAX_REGS = 125;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  FUNC_READ_IN  = 8'h04;
  localparam logic [8:0]  HDR_TRL_LEN   = 9'd5;
  localparam logic [7:0]  POS_SAT       = 8'hFF;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS  = 1'b0;
  localparam logic CFG_REG_CNT        = 1'b1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SHORT   = 3'd1,
    ST_CRC_ERROR   = 3'd2,
    ST_WRONG_SLAVE = 3'd3,
    ST_EXCEPTION   = 3'd4,
    ST_MALFORMED   = 3'd5
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] exc_code;
  } result_t;

  // One byte of the reflected CRC-16, unrolled over eight bit steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/mrc_frame_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrc_frame_chk
// Per-frame state of one reply: position, running CRC, captured header
// fields and CRC check flags. Gives the status on the final word.
// ----------------------------------------------------------------------------
module mrc_frame_chk
  import mrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_end,
  input  wire logic [7:0] slave_address,
  input  wire logic [6:0] reg_cnt,
  output result_t         result
);

  logic [7:0]  pos_r,        pos_nxt;
  logic [15:0] crc_r,        crc_nxt;
  logic        exc_seen_r,   exc_seen_nxt;
  logic        slave_ok_r,   slave_ok_nxt;
  logic        hdr_ok_r,     hdr_ok_nxt;
  logic [7:0]  held_code_r,  held_code_nxt;
  logic [7:0]  crc_low_r,    crc_low_nxt;
  logic [15:0] snap_crc_r,   snap_crc_nxt;
  logic        exc_good_r,   exc_good_nxt;
  logic        norm_good_r,  norm_good_nxt;

  logic [8:0]  exp_frame_len;
  logic [8:0]  pos_p1;
  logic [8:0]  pos_p2;
  logic        live;
  logic        rx_crc_match;

  assign exp_frame_len = HDR_TRL_LEN + {1'b0, reg_cnt, 1'b0};
  assign pos_p1        = {1'b0, pos_r} + 9'd1;
  assign pos_p2        = {1'b0, pos_r} + 9'd2;
  assign live          = (pos_r != POS_SAT);
  assign rx_crc_match  = (snap_crc_r == {rx_byte, crc_low_r});

  // Field capture for this word
  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    exc_seen_nxt  = exc_seen_r;
    slave_ok_nxt  = slave_ok_r;
    hdr_ok_nxt    = hdr_ok_r;
    held_code_nxt = held_code_r;
    crc_low_nxt   = crc_low_r;
    snap_crc_nxt  = snap_crc_r;
    exc_good_nxt  = exc_good_r;
    norm_good_nxt = norm_good_r;
    if (live) begin
      if (pos_r == 8'd0) begin
        slave_ok_nxt = (rx_byte == slave_address);
      end
      if (pos_r == 8'd1) begin
        exc_seen_nxt = rx_byte[7];
        hdr_ok_nxt   = (rx_byte == FUNC_READ_IN);
      end
      if (pos_r == 8'd2) begin
        held_code_nxt = rx_byte;
        hdr_ok_nxt    = hdr_ok_r && (rx_byte == {reg_cnt, 1'b0});
      end
      // CRC low byte arrives: snapshot the CRC of the bytes before it
      if (pos_r == 8'd3 || pos_p2 == exp_frame_len) begin
        snap_crc_nxt = crc_r;
        crc_low_nxt  = rx_byte;
      end
      if (pos_r == 8'd4) begin
        exc_good_nxt = rx_crc_match;
      end
      if (pos_p1 == exp_frame_len) begin
        norm_good_nxt = rx_crc_match;
      end
      crc_nxt = crc16_byte(crc_r, rx_byte);
      pos_nxt = pos_p1[7:0];
    end
  end

  // Decision on the final word, using the state as updated by it
  always_comb begin
    result.status   = ST_OK;
    result.exc_code = 8'h00;
    if (pos_r >= 8'd4 && exc_seen_nxt) begin
      if (exc_good_nxt) begin
        result.status   = ST_EXCEPTION;
        result.exc_code = held_code_nxt;
      end else begin
        result.status = ST_CRC_ERROR;
      end
    end else if ({25'd0, reg_cnt} > MAX_REGS || pos_p1 < exp_frame_len) begin
      result.status = ST_TOO_SHORT;
    end else if (!norm_good_nxt) begin
      result.status = ST_CRC_ERROR;
    end else if (!slave_ok_nxt) begin
      result.status = ST_WRONG_SLAVE;
    end else if (!hdr_ok_nxt) begin
      result.status = ST_MALFORMED;
    end
  end

  // Frame state; cleared on reset and after each final word
  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      pos_r       <= 8'd0;
      crc_r       <= CRC_INIT;
      exc_seen_r  <= 1'b0;
      slave_ok_r  <= 1'b0;
      hdr_ok_r    <= 1'b0;
      held_code_r <= 8'h00;
      crc_low_r   <= 8'h00;
      snap_crc_r  <= 16'h0000;
      exc_good_r  <= 1'b0;
      norm_good_r <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      exc_seen_r  <= exc_seen_nxt;
      slave_ok_r  <= slave_ok_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      held_code_r <= held_code_nxt;
      crc_low_r   <= crc_low_nxt;
      snap_crc_r  <= snap_crc_nxt;
      exc_good_r  <= exc_good_nxt;
      norm_good_r <= norm_good_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/modbus_rtu_response_checker_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// A final word's status goes through the input register, then the result register.
// Throughput: one word per cycle; the frame logic sits between the input register
// and the result register. A final word waits only if the result register is full
// and stalled. Reset (synchronous, rst_n low) empties both registers, clears frame
// state and loads slave address 1 and register count 2.
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core
// Checks a Modbus RTU read-input-registers reply word by word and reports
// one status per frame: ok, too short, CRC error, wrong slave, exception
// or malformed.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core
  import mrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_end,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_exc_code
);

  logic [7:0] slave_address_r;
  logic [6:0] reg_cnt_r;

  logic       s1_valid_r;
  logic [7:0] s1_rx_byte_r;
  logic       s1_frame_end_r;
  logic       s1_go;

  logic       out_valid_r;
  result_t    out_res_r;
  result_t    frame_res;
  logic       out_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r <= 8'd1;
      reg_cnt_r       <= 7'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: slave_address_r <= cfg_wdata;
        CFG_REG_CNT:       reg_cnt_r       <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Hold a final word only while the result register cannot take it
  assign in_stall = s1_valid_r && s1_frame_end_r && out_valid_r && out_stall;
  assign s1_go    = s1_valid_r && !in_stall;
  assign out_load = s1_go && s1_frame_end_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_rx_byte_r   <= in_rx_byte;
      s1_frame_end_r <= in_frame_end;
    end
  end

  mrc_frame_chk u_frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_go),
    .rx_byte        (s1_rx_byte_r),
    .frame_end      (s1_frame_end_r),
    .slave_address  (slave_address_r),
    .reg_cnt        (reg_cnt_r),
    .result         (frame_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= frame_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_res_r.status;
  assign out_exc_code = out_res_r.exc_code;

  // A new result only follows a final word leaving the input register
  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_frame_end_r))
    else $error("result appeared without a final word");

  // Exception code is zero for every non-exception status
  a_code_only_on_exc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_EXCEPTION) |-> out_res_r.exc_code == 8'h00)
    else $error("exception code set on non-exception status");

  // The input side waits only behind a final word and a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_frame_end_r && out_valid_r))
    else $error("input stalled without a pending final word");

endmodule
`default_nettype wire
